// ===== rtl/core/tsbf_pkg.sv =====
// Shared types, constants and codes for the topic subscriber bitmap fanout.
`default_nettype none
package tsbf_pkg;
  localparam int SLOTS = 64;
  localparam int TOPICS = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = SLOT_W + 1;
  localparam int TOPIC_W = $clog2(TOPICS);
  localparam logic [6:0] MAX_SUB_RESET = 7'd60;

  localparam logic [1:0] OP_SUBSCRIBE = 2'd0;
  localparam logic [1:0] OP_UNSUBSCRIBE = 2'd1;
  localparam logic [1:0] OP_PUBLISH = 2'd2;
  // Operation code that the block ignores.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_NOTIFY = 3'd2;
  localparam logic [2:0] ST_NOTHING = 3'd3;
  localparam logic [2:0] ST_NOT_SUB = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] topic;
    logic [31:0] subscriber_id;
    logic [15:0] handler;
    logic [31:0] handler_arg;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot;
    logic [31:0] notify_id;
    logic [15:0] notify_handler;
    logic [31:0] notify_arg;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] handler;
    logic [31:0] arg;
  } entry_t;
endpackage
`default_nettype wire

// ===== rtl/core/tsbf_entry_ram.sv =====
// Subscriber entry memory: one write port, one registered read port.
`default_nettype none
module tsbf_entry_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [tsbf_pkg::SLOT_W-1:0] waddr,
  input  wire tsbf_pkg::entry_t            wdata,
  input  wire logic [tsbf_pkg::SLOT_W-1:0] raddr,
  output tsbf_pkg::entry_t                 rdata
);
  import tsbf_pkg::*;
  entry_t mem [SLOTS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/tsbf_bitmap_ram.sv =====
// Topic bitmap memory with valid bits standing in for the cleared reset value.
`default_nettype none
module tsbf_bitmap_ram (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         we,
  input  wire logic [tsbf_pkg::TOPIC_W-1:0] waddr,
  input  wire logic [tsbf_pkg::SLOTS-1:0]   wdata,
  input  wire logic [tsbf_pkg::TOPIC_W-1:0] raddr,
  output logic [tsbf_pkg::SLOTS-1:0]        rdata
);
  import tsbf_pkg::*;
  logic [SLOTS-1:0] mem [TOPICS];
  logic [TOPICS-1:0] vld_r;
  logic [SLOTS-1:0] raw_r;
  logic hit_r;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    raw_r <= mem[raddr];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (we) vld_r[waddr] <= 1'b1;
      hit_r <= vld_r[raddr];
    end
  end
  assign rdata = hit_r ? raw_r : '0;
endmodule
`default_nettype wire

// ===== rtl/core/topic_subscriber_bitmap_fanout.sv =====
// Top level: publish/subscribe table with per-topic slot bitmaps.
`default_nettype none
// Usage:
//   Input channel in_valid/in_stall/in_data carries one operation transaction
//   (subscribe, unsubscribe, publish). Result channel out_valid/out_stall/
//   out_data returns the results; last marks the final one of an operation.
//   cfg_valid/cfg_ready/cfg_data writes max_subscribers; write only when idle.
// Timing:
//   One operation at a time. Subscribe and unsubscribe walk the entry memory
//   one slot per cycle over the current entry count, then register the result
//   and, on success, update the bitmap (and the entry memory for a new entry).
//   Publish reads the topic bitmap, then walks all SLOTS slots, one per cycle
//   while the output register is free, emitting each hit, then registers the
//   final result. The next transaction is taken once it is registered.
// Reset:
//   Synchronous active-low rst_n clears the entry count, the topic bitmap
//   valid bits (so every bitmap reads zero) and sets capacity to 60.
// Backpressure:
//   A result sits in the output register while out_stall is high; the publish
//   walk and the final states wait until it is free, so nothing is lost.
module topic_subscriber_bitmap_fanout (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tsbf_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tsbf_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [6:0]          cfg_data
);
  import tsbf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BMRD = 3'd1; // bitmap read in flight
  localparam logic [2:0] S_SCAN = 3'd2; // walk entries
  localparam logic [2:0] S_DONE = 3'd3; // finish subscribe/unsubscribe
  localparam logic [2:0] S_EMIT = 3'd4; // emit final result, wait slot free

  logic [2:0] state_r, state_nxt;
  in_item_t req_r;
  logic [6:0] max_sub_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;      // address issued this cycle
  logic rd_pend_r;              // entry data valid this cycle
  logic [SLOT_W-1:0] rd_slot_r;
  logic [SLOTS-1:0] bm_r;
  logic found_r;
  logic [SLOT_W-1:0] found_slot_r;
  logic any_r;
  out_item_t pend_r;            // last publish hit, held to set last bit
  logic pend_vld_r;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r;

  entry_t ent_rd, ent_wd;
  logic ent_we;
  logic [SLOT_W-1:0] ent_ra;
  logic [SLOTS-1:0] bm_rd, bm_wd;
  logic bm_we;
  logic [TOPIC_W-1:0] bm_ra;

  tsbf_entry_ram u_ent (.clk, .we(ent_we), .waddr(count_r[SLOT_W-1:0]),
    .wdata(ent_wd), .raddr(ent_ra), .rdata(ent_rd));
  tsbf_bitmap_ram u_bm (.clk, .rst_n, .we(bm_we), .waddr(req_r.topic[TOPIC_W-1:0]),
    .wdata(bm_wd), .raddr(bm_ra), .rdata(bm_rd));

  wire out_free = !out_valid_r || !out_stall;
  wire is_pub = req_r.operation == OP_PUBLISH;
  wire [CNT_W-1:0] limit = is_pub ? CNT_W'(SLOTS) : count_r;
  wire [CNT_W-1:0] cap = (max_sub_r > 7'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(max_sub_r);
  wire hit = rd_pend_r && (is_pub ?
               (bm_r[rd_slot_r] && ent_rd.handler != '0) :
               (!found_r && ent_rd.id == req_r.subscriber_id &&
                ent_rd.handler == req_r.handler));
  // Publish emits the held hit when a newer one arrives; that needs the output.
  wire scan_go = out_free || !is_pub;
  wire issue = scan_go && idx_r < limit;

  assign in_stall = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  // Re-read the slot under evaluation while the walk is held.
  assign ent_ra = (state_r == S_SCAN && !scan_go) ? rd_slot_r : idx_r[SLOT_W-1:0];
  // Read the bitmap of the incoming transaction at its accepting edge.
  assign bm_ra = (state_r == S_IDLE) ? in_data.topic[TOPIC_W-1:0]
                                     : req_r.topic[TOPIC_W-1:0];
  // Load the output register on a publish hit that pushes out the held one or
  // on a final result; otherwise hold while stalled.
  assign out_valid_nxt = (state_r == S_SCAN && scan_go && is_pub && hit && pend_vld_r) ||
                         ((state_r == S_DONE || state_r == S_EMIT) && out_free) ||
                         (out_valid_r && out_stall);

  logic [SLOT_W-1:0] dslot;
  logic dnew, dok;
  always_comb begin
    dnew = !found_r && req_r.operation == OP_SUBSCRIBE && count_r < cap;
    dok = found_r || dnew;
    dslot = found_r ? found_slot_r : count_r[SLOT_W-1:0];
    ent_we = state_r == S_DONE && out_free && dnew;
    ent_wd = '{id: req_r.subscriber_id, handler: req_r.handler, arg: req_r.handler_arg};
    bm_we = state_r == S_DONE && out_free && dok;
    bm_wd = (req_r.operation == OP_SUBSCRIBE) ? (bm_r | (SLOTS'(1) << dslot))
                                              : (bm_r & ~(SLOTS'(1) << dslot));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid && in_data.operation != OP_RESERVED) state_nxt = S_BMRD;
      S_BMRD: state_nxt = S_SCAN;
      S_SCAN: if (scan_go && !issue && !rd_pend_r)
                state_nxt = is_pub ? S_EMIT : S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      S_EMIT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_sub_r <= MAX_SUB_RESET;
      count_r <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) max_sub_r <= cfg_data;
      out_valid_r <= out_valid_nxt;
      if (ent_we) count_r <= count_r + 1'b1;
      unique case (state_r)
        S_IDLE: begin
          rd_pend_r <= 1'b0;
          pend_vld_r <= 1'b0;
        end
        S_BMRD: rd_pend_r <= 1'b0;
        S_SCAN: if (scan_go) begin
          rd_pend_r <= issue;
          if (hit && is_pub) pend_vld_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        req_r <= in_data;
        idx_r <= '0;
        found_r <= 1'b0;
        any_r <= 1'b0;
      end
      S_BMRD: bm_r <= bm_rd;
      S_SCAN: if (scan_go) begin
        if (issue) idx_r <= idx_r + 1'b1;
        rd_slot_r <= idx_r[SLOT_W-1:0];
        if (hit) begin
          found_r <= 1'b1;
          found_slot_r <= rd_slot_r;
          any_r <= 1'b1;
          pend_r <= '{status: ST_NOTIFY, slot: rd_slot_r, notify_id: ent_rd.id,
                      notify_handler: ent_rd.handler, notify_arg: ent_rd.arg,
                      last: 1'b0};
          if (is_pub && pend_vld_r) out_r <= pend_r;
        end
      end
      S_DONE: if (out_free)
        out_r <= '{status: dok ? ST_OK :
                   (req_r.operation == OP_SUBSCRIBE ? ST_NO_SPACE : ST_NOT_SUB),
                   slot: dok ? dslot : '0, notify_id: '0, notify_handler: '0,
                   notify_arg: '0, last: 1'b1};
      S_EMIT: if (out_free) begin
        if (any_r) begin
          out_r <= '{status: pend_r.status, slot: pend_r.slot,
                     notify_id: pend_r.notify_id, notify_handler: pend_r.notify_handler,
                     notify_arg: pend_r.notify_arg, last: 1'b1};
        end else begin
          out_r <= '{status: ST_NOTHING, slot: '0, notify_id: '0,
                     notify_handler: '0, notify_arg: '0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOTS)) else $error("entry count beyond table");
  a_idle_noout: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && $past(state_r) == S_IDLE && !$past(out_valid_r)
    |-> !out_valid_r)
    else $error("result without operation");
  a_we_room: assert property (@(posedge clk) disable iff (!rst_n)
    ent_we |-> count_r < cap) else $error("append beyond capacity");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");
endmodule
`default_nettype wire

// ===== bench/tb_topic_subscriber_bitmap_fanout.sv =====
// Testbench for the topic subscriber bitmap fanout: directed, capacity, random, stall and full-table tests.
`default_nettype none
module tb_topic_subscriber_bitmap_fanout;
  timeunit 1ns;
  timeprecision 1ps;
  import tsbf_pkg::*;

  localparam int DRAIN_CYCLES = 90;
  localparam longint CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  // Shadow of the subscriber table and topic bitmaps.
  logic [31:0] sub_ids [SLOTS];
  logic [15:0] sub_handlers [SLOTS];
  logic [31:0] sub_args [SLOTS];
  int          sub_count;
  logic [63:0] topic_map [TOPICS];
  logic [6:0]  capacity_reg;

  out_item_t   pending_results [$];
  int          mismatches = 0;
  longint      cycle_count = 0;
  bit          in_gaps_on = 1'b1;
  bit          out_gaps_on = 1'b1;
  bit          hold_results = 1'b0;
  int          out_gap_left = 0;

  // Pool of well-formed subscribers so random traffic hits existing entries.
  logic [31:0] pool_ids [16];
  logic [15:0] pool_handlers [16];

  topic_subscriber_bitmap_fanout i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL topic_subscriber_bitmap_fanout");
      $finish;
    end
  end

  function automatic int lookup_entry(logic [31:0] id, logic [15:0] hnd);
    for (int i = 0; i < sub_count; i++)
      if (sub_ids[i] == id && sub_handlers[i] == hnd) return i;
    return -1;
  endfunction

  function automatic out_item_t status_result(logic [2:0] st, int slot);
    out_item_t r;
    r = '0;
    r.status = st;
    r.slot = slot[5:0];
    r.last = 1'b1;
    return r;
  endfunction

  // Update the shadow state for one accepted transaction and queue its results.
  function automatic void apply_operation(in_item_t it);
    int s;
    int cap;
    int hits;
    out_item_t r;
    hits = 0;
    case (it.operation)
      OP_SUBSCRIBE: begin
        cap = (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
        s = lookup_entry(it.subscriber_id, it.handler);
        if (s < 0 && sub_count < cap) begin
          s = sub_count;
          sub_ids[s] = it.subscriber_id;
          sub_handlers[s] = it.handler;
          sub_args[s] = it.handler_arg;
          sub_count++;
        end
        if (s < 0) begin
          pending_results.push_back(status_result(ST_NO_SPACE, 0));
        end else begin
          topic_map[it.topic][s] = 1'b1;
          pending_results.push_back(status_result(ST_OK, s));
        end
      end
      OP_UNSUBSCRIBE: begin
        s = lookup_entry(it.subscriber_id, it.handler);
        if (s < 0) begin
          pending_results.push_back(status_result(ST_NOT_SUB, 0));
        end else begin
          topic_map[it.topic][s] = 1'b0;
          pending_results.push_back(status_result(ST_OK, s));
        end
      end
      OP_PUBLISH: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (topic_map[it.topic][i] && sub_handlers[i] != 16'd0) begin
            r = '0;
            r.status = ST_NOTIFY;
            r.slot = i[5:0];
            r.notify_id = sub_ids[i];
            r.notify_handler = sub_handlers[i];
            r.notify_arg = sub_args[i];
            pending_results.push_back(r);
            hits++;
          end
        end
        // Mark the final notify, or report an empty fanout.
        if (hits == 0) pending_results.push_back(status_result(ST_NOTHING, 0));
        else pending_results[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Compare every accepted result against the oldest pending expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      out_gap_left = out_gaps_on ? $urandom_range(0, 10) : 0;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.slot !== want.slot ||
            out_data.notify_id !== want.notify_id ||
            out_data.notify_handler !== want.notify_handler ||
            out_data.notify_arg !== want.notify_arg || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p actual %p", want, out_data);
        end
      end
    end
  end

  // Drive result backpressure: per-result random gaps plus an optional long hold.
  always @(negedge clk) begin
    out_stall <= hold_results || out_gap_left > 0;
    if (out_gap_left > 0) out_gap_left--;
  end

  // Offer one transaction, after a random gap if gaps are on; hold it until accepted.
  task automatic send_op(in_item_t it);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    apply_operation(it);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [1:0] op, logic [7:0] topic, logic [31:0] id,
                             logic [15:0] hnd, logic [31:0] arg);
    in_item_t it;
    it.operation = op;
    it.topic = topic;
    it.subscriber_id = id;
    it.handler = hnd;
    it.handler_arg = arg;
    send_op(it);
  endtask

  // Drop valid and wait until every expected result is in, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Field extremes, every operation, handler 0 skip, stale unsubscribe, ignored code.
  task automatic test_directed();
    send_fields(OP_SUBSCRIBE, 8'd0, 32'd0, 16'd0, 32'd0);
    send_fields(OP_SUBSCRIBE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_fields(OP_SUBSCRIBE, 8'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'h1234_5678);
    send_fields(OP_PUBLISH, 8'd0, 32'd0, 16'd0, 32'd0);
    send_fields(OP_PUBLISH, 8'hFF, 32'd0, 16'd0, 32'd0);
    send_fields(OP_PUBLISH, 8'd9, 32'd0, 16'd0, 32'd0);
    send_fields(OP_UNSUBSCRIBE, 8'd0, 32'hAAAA_5555, 16'h5A5A, 32'd0);
    send_fields(OP_UNSUBSCRIBE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    send_fields(OP_UNSUBSCRIBE, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    send_fields(OP_PUBLISH, 8'hFF, 32'd0, 16'd0, 32'd0);
    send_fields(OP_RESERVED, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_fields(OP_SUBSCRIBE, 8'd0, 32'd0, 16'd0, 32'd7);
    send_fields(OP_PUBLISH, 8'd0, 32'd0, 16'd0, 32'd0);
    wait_drained();
  endtask

  // Capacity zero and capacity below the entry count: known entries still match.
  task automatic test_capacity_limits();
    write_capacity(7'd0);
    send_fields(OP_SUBSCRIBE, 8'd3, 32'hCAFE_0001, 16'h0011, 32'd1);
    send_fields(OP_SUBSCRIBE, 8'd3, 32'hFFFF_FFFF, 16'hFFFF, 32'd1);
    send_fields(OP_PUBLISH, 8'd3, 32'd0, 16'd0, 32'd0);
    wait_drained();
    write_capacity(7'd1);
    send_fields(OP_SUBSCRIBE, 8'd4, 32'hCAFE_0002, 16'h0022, 32'd2);
    send_fields(OP_SUBSCRIBE, 8'd4, 32'd0, 16'd0, 32'd2);
    wait_drained();
    write_capacity(MAX_SUB_RESET);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int p;
    int pick;
    p = $urandom_range(0, 15);
    pick = $urandom_range(0, 99);
    it.subscriber_id = pool_ids[p];
    it.handler = pool_handlers[p];
    it.handler_arg = $urandom();
    it.topic = 8'($urandom_range(0, 5));
    if (pick < 40) it.operation = OP_SUBSCRIBE;
    else if (pick < 60) it.operation = OP_UNSUBSCRIBE;
    else if (pick < 92) it.operation = OP_PUBLISH;
    else it.operation = OP_RESERVED;
    // Noise: fresh keys and topics anywhere in the range.
    if ($urandom_range(0, 9) == 0) begin
      it.subscriber_id = $urandom();
      it.handler = 16'($urandom());
      it.topic = 8'($urandom());
    end
    return it;
  endfunction

  // Random well-formed traffic over a small subscriber pool, idling toggled in stretches.
  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 30 == 0) begin
        in_gaps_on = $urandom_range(0, 2) != 0;
        out_gaps_on = $urandom_range(0, 2) != 0;
      end
      send_op(random_item());
    end
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    wait_drained();
  endtask

  // Hold results off for a long stretch while transactions keep coming.
  task automatic test_backpressure();
    in_gaps_on = 1'b0;
    fork
      begin
        hold_results = 1'b1;
        repeat (400) @(posedge clk);
        hold_results = 1'b0;
      end
    join_none
    for (int n = 0; n < 12; n++)
      send_fields(OP_PUBLISH, 8'(n % 6), 32'd0, 16'd0, 32'd0);
    in_gaps_on = 1'b1;
    wait_drained();
  endtask

  // Fill the table, new entries on topic 200; overflow once; publish 200; resubscribe slot 63 to 201.
  task automatic test_full_table();
    write_capacity(7'd127);
    while (sub_count < SLOTS)
      send_fields(OP_SUBSCRIBE, 8'd200, $urandom(), 16'($urandom_range(1, 65535)),
                  $urandom());
    send_fields(OP_SUBSCRIBE, 8'd200, 32'h0BAD_F00D, 16'h7777, 32'd0);
    send_fields(OP_PUBLISH, 8'd200, 32'd0, 16'd0, 32'd0);
    wait_drained();
    write_capacity(7'd64);
    send_fields(OP_SUBSCRIBE, 8'd201, sub_ids[63], sub_handlers[63], 32'd0);
    send_fields(OP_PUBLISH, 8'd201, 32'd0, 16'd0, 32'd0);
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < TOPICS; i++) topic_map[i] = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sub_ids[i] = '0;
      sub_handlers[i] = '0;
      sub_args[i] = '0;
    end
    sub_count = 0;
    capacity_reg = MAX_SUB_RESET;
    for (int i = 0; i < 16; i++) begin
      pool_ids[i] = $urandom();
      // Keep a few handler-less subscribers to exercise the publish skip.
      pool_handlers[i] = (i % 5 == 0) ? 16'd0 : 16'($urandom());
    end

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_capacity_limits();
    test_random(80);
    test_backpressure();
    test_full_table();

    if (mismatches == 0) begin
      $display("PASS topic_subscriber_bitmap_fanout");
    end else begin
      $display("FAIL topic_subscriber_bitmap_fanout");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== topic_subscriber_bitmap_fanout.f =====
rtl/core/tsbf_pkg.sv
rtl/core/tsbf_entry_ram.sv
rtl/core/tsbf_bitmap_ram.sv
rtl/core/topic_subscriber_bitmap_fanout.sv
bench/tb_topic_subscriber_bitmap_fanout.sv
